>>> rtl/arith_expression_tokenizer_unit_assert.svh
// Assertion helpers used by aet_back.
`ifndef ARITH_EXPRESSION_TOKENIZER_UNIT_ASSERT_SVH
`define ARITH_EXPRESSION_TOKENIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define AET_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AET_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/aet_pkg.sv
package aet_pkg;

  localparam int MANT_W = 31;
  localparam int FRAC_W = 4;

  localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd15;

  localparam logic [2:0] KIND_INT = 3'd0;
  localparam logic [2:0] KIND_DEC = 3'd1;
  localparam logic [2:0] KIND_ADD = 3'd2;
  localparam logic [2:0] KIND_SUB = 3'd3;
  localparam logic [2:0] KIND_MUL = 3'd4;
  localparam logic [2:0] KIND_DIV = 3'd5;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  typedef enum logic [2:0] {
    CLS_DIGIT = 3'd0,
    CLS_POINT = 3'd1,
    CLS_OP    = 3'd2,
    CLS_OTHER = 3'd3,
    CLS_EOT   = 3'd4
  } cls_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } src_t;

  typedef struct packed {
    logic [2:0]        token_kind;
    logic [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0] fraction_digits;
    logic              overflow;
    logic              last_of_run;
  } tok_t;

  // classified character as it sits in the queue
  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
    logic [2:0] op_kind;
  } cls_t;

endpackage

>>> rtl/aet_front.sv
module aet_front import aet_pkg::*; (
  input  src_t src_word,
  input  logic src_valid,
  output logic src_stall,
  output cls_t push_word,
  output logic push,
  input  logic q_full
);

  logic [7:0] diff;

  assign diff      = src_word.ch - CH_0;
  assign src_stall = q_full;
  assign push      = src_valid && !q_full;

  always_comb begin
    push_word.digit   = diff[3:0];
    push_word.op_kind = KIND_ADD;
    push_word.cls     = CLS_OTHER;
    if (src_word.end_of_text) begin
      push_word.cls = CLS_EOT;
    end else if (src_word.ch >= CH_0 && src_word.ch <= CH_9) begin
      push_word.cls = CLS_DIGIT;
    end else begin
      case (src_word.ch)
        CH_POINT: push_word.cls = CLS_POINT;
        CH_PLUS: begin
          push_word.cls     = CLS_OP;
          push_word.op_kind = KIND_ADD;
        end
        CH_MINUS: begin
          push_word.cls     = CLS_OP;
          push_word.op_kind = KIND_SUB;
        end
        CH_STAR: begin
          push_word.cls     = CLS_OP;
          push_word.op_kind = KIND_MUL;
        end
        CH_SLASH: begin
          push_word.cls     = CLS_OP;
          push_word.op_kind = KIND_DIV;
        end
        CH_SPACE: push_word.cls = CLS_OTHER;
        default:  push_word.cls = CLS_OTHER;
      endcase
    end
  end

endmodule

>>> rtl/aet_queue.sv
module aet_queue import aet_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cls_t push_word,
  output logic full,
  input  logic pop,
  output cls_t head,
  output logic head_valid
);

  cls_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_word;
        wr_ptr        <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/aet_back.sv
module aet_back import aet_pkg::*; #(
  parameter int MANTISSA_BITS = 31
) (
  input  logic clk,
  input  logic rst,
  input  cls_t q_word,
  input  logic q_valid,
  output logic q_pop,
  output tok_t tok_word,
  output logic tok_valid,
  input  logic tok_stall
);

  `include "arith_expression_tokenizer_unit_assert.svh"

  localparam int MW = MANTISSA_BITS;
  localparam int PW = MW + 4;
  localparam int XW = (MW > MANT_W) ? MW : MANT_W;

  logic              in_number,   in_number_next;
  logic              in_fraction, in_fraction_next;
  logic [MW-1:0]     acc,         acc_next;
  logic [FRAC_W-1:0] frac_cnt,    frac_cnt_next;
  logic              saturated,   saturated_next;
  logic              op_pending;
  logic [2:0]        op_kind;

  logic          emit_ok;
  logic          is_op;
  logic          flush_req;
  logic [PW-1:0] prod;
  logic          acc_ovf;
  logic [XW-1:0] acc_x;
  tok_t          num_tok;
  tok_t          op_tok;
  tok_t          pend_tok;

  assign emit_ok = !tok_valid || !tok_stall;
  assign q_pop   = q_valid && !op_pending && emit_ok;
  assign is_op   = (q_word.cls == CLS_OP);

  // a number ends on anything but a digit or its first point
  assign flush_req = in_number && (q_word.cls == CLS_EOT || q_word.cls == CLS_OTHER ||
                     q_word.cls == CLS_OP || (q_word.cls == CLS_POINT && in_fraction));

  // acc*10 + d as shift-add
  assign prod    = (PW'(acc) << 3) + (PW'(acc) << 1) + PW'(q_word.digit);
  assign acc_ovf = (prod[PW-1:MW] != '0);
  assign acc_x   = XW'(acc);

  always_comb begin
    num_tok.token_kind      = in_fraction ? KIND_DEC : KIND_INT;
    num_tok.mantissa        = acc_x[MANT_W-1:0];
    num_tok.fraction_digits = in_fraction ? frac_cnt : '0;
    num_tok.overflow        = saturated;
    num_tok.last_of_run     = !is_op;

    op_tok.token_kind      = q_word.op_kind;
    op_tok.mantissa        = '0;
    op_tok.fraction_digits = '0;
    op_tok.overflow        = 1'b0;
    op_tok.last_of_run     = 1'b1;

    pend_tok            = op_tok;
    pend_tok.token_kind = op_kind;
  end

  always_comb begin
    in_number_next   = in_number;
    in_fraction_next = in_fraction;
    acc_next         = acc;
    frac_cnt_next    = frac_cnt;
    saturated_next   = saturated;
    case (q_word.cls)
      CLS_DIGIT: begin
        if (!in_number) begin
          in_number_next   = 1'b1;
          in_fraction_next = 1'b0;
          acc_next         = MW'(q_word.digit);
          frac_cnt_next    = '0;
          saturated_next   = 1'b0;
        end else begin
          acc_next       = acc_ovf ? {MW{1'b1}} : prod[MW-1:0];
          saturated_next = saturated || acc_ovf || (in_fraction && frac_cnt == FRAC_MAX);
          if (in_fraction && frac_cnt != FRAC_MAX) begin
            frac_cnt_next = frac_cnt + 4'd1;
          end
        end
      end
      CLS_POINT: begin
        if (in_number && !in_fraction) begin
          in_fraction_next = 1'b1;
        end else begin
          in_number_next   = 1'b0;
          in_fraction_next = 1'b0;
          acc_next         = '0;
          frac_cnt_next    = '0;
          saturated_next   = 1'b0;
        end
      end
      default: begin
        in_number_next   = 1'b0;
        in_fraction_next = 1'b0;
        acc_next         = '0;
        frac_cnt_next    = '0;
        saturated_next   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_number   <= 1'b0;
      in_fraction <= 1'b0;
      acc         <= '0;
      frac_cnt    <= '0;
      saturated   <= 1'b0;
      op_pending  <= 1'b0;
      tok_valid   <= 1'b0;
    end else begin
      if (op_pending && emit_ok) begin
        tok_valid  <= 1'b1;
        tok_word   <= pend_tok;
        op_pending <= 1'b0;
      end else if (q_pop) begin
        in_number   <= in_number_next;
        in_fraction <= in_fraction_next;
        acc         <= acc_next;
        frac_cnt    <= frac_cnt_next;
        saturated   <= saturated_next;
        if (flush_req) begin
          tok_valid  <= 1'b1;
          tok_word   <= num_tok;
          op_pending <= is_op;
          op_kind    <= q_word.op_kind;
        end else if (is_op) begin
          tok_valid <= 1'b1;
          tok_word  <= op_tok;
        end else begin
          tok_valid <= 1'b0;
        end
      end else if (emit_ok) begin
        tok_valid <= 1'b0;
      end
    end
  end

  `AET_ASSERT_IMP(a_pend_out, clk, rst, op_pending, tok_valid,
                  "operator pending without number word on output")
  `AET_ASSERT_IMP(a_nonlast_num, clk, rst, tok_valid && !tok_word.last_of_run,
                  tok_word.token_kind == KIND_INT || tok_word.token_kind == KIND_DEC,
                  "non-final word is not a number")
  `AET_ASSERT_IMP(a_frac_in_num, clk, rst, in_fraction, in_number,
                  "fraction flag outside a number")
  `AET_ASSERT_IMP(a_cnt_in_frac, clk, rst, frac_cnt != '0, in_fraction,
                  "fraction count outside fraction")
  `AET_ASSERT_NXT(a_pend_clears, clk, rst, op_pending && !tok_stall, !op_pending,
                  "operator word not sent when output was free")

endmodule

>>> rtl/arith_expression_tokenizer_unit.sv
// The character word that ends a token goes into a queue slot; the back end pops it
//   and registers that token on tok_word.
// Throughput: one character per cycle while tok_stall is low; a number ended by an
//   operator makes two tokens, pausing queue pops, so the 2-entry queue may fill.
// Output is registered; tok_stall reaches the queue pop only, not src_stall directly.
// Reset (synchronous, rst high): queue emptied, no token pending, number state cleared.
module arith_expression_tokenizer_unit import aet_pkg::*; #(
  parameter int MANTISSA_BITS = 31
) (
  input  logic clk,
  input  logic rst,
  input  src_t src_word,
  input  logic src_valid,
  output logic src_stall,
  output tok_t tok_word,
  output logic tok_valid,
  input  logic tok_stall
);

  cls_t push_word;
  logic push;
  logic q_full;
  cls_t q_word;
  logic q_valid;
  logic q_pop;

  aet_front u_front (
    .src_word  (src_word),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .push_word (push_word),
    .push      (push),
    .q_full    (q_full)
  );

  aet_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_word),
    .head_valid (q_valid)
  );

  aet_back #(
    .MANTISSA_BITS (MANTISSA_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_word    (q_word),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .tok_word  (tok_word),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall)
  );

endmodule

>>> test/arith_expression_tokenizer_unit_test.sv
`timescale 1ns / 1ps

module arith_expression_tokenizer_unit_test;
  import aet_pkg::*;

  localparam int RANDOM_WORDS = 1700;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [63:0] MANT_MAX = (64'd1 << MANT_W) - 64'd1;

  typedef struct packed {
    logic              open_num;
    logic              after_point;
    logic              clipped;
    logic [MANT_W-1:0] value;
    logic [FRAC_W-1:0] places;
  } num_state_t;

  typedef struct {
    src_t word;
    bit   typed;
    tok_t tok;
  } char_row_t;

  logic clk;
  logic rst;
  src_t src_word;
  logic src_valid;
  logic src_stall;
  tok_t tok_word;
  logic tok_valid;
  logic tok_stall;

  num_state_t num = '0;
  tok_t       expected_tokens[$];
  char_row_t  offered_rows[$];
  char_row_t  directed_rows[$];

  int mismatches = 0;
  int idle_cycles = 0;
  int chars_seen = 0;
  int chars_used = 0;
  int sent_chars = 0;
  int clipped_seen = 0;
  int kind_seen[6] = '{default: 0};
  bit hold_req = 1'b0;
  bit no_gaps = 1'b0;

  arith_expression_tokenizer_unit #(.MANTISSA_BITS(MANT_W)) i_dut (
    .clk(clk),
    .rst(rst),
    .src_word(src_word),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .tok_word(tok_word),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic tok_t make_tok(logic [2:0] kind, logic [63:0] mant,
                                    logic [FRAC_W-1:0] frac, logic ovf, logic last);
    tok_t t;
    t.token_kind = kind;
    t.mantissa = mant[MANT_W-1:0];
    t.fraction_digits = frac;
    t.overflow = ovf;
    t.last_of_run = last;
    return t;
  endfunction

  function automatic tok_t close_number();
    tok_t t;
    if (num.after_point) begin
      t = make_tok(KIND_DEC, 64'(num.value), num.places, num.clipped, 1'b0);
    end else begin
      t = make_tok(KIND_INT, 64'(num.value), 4'd0, num.clipped, 1'b0);
    end
    num = '0;
    return t;
  endfunction

  // advances the number state by one character word; returns the number of tokens made
  function automatic int tokenize_word(src_t w, output tok_t made[2]);
    int n;
    logic [63:0] d;
    n = 0;
    made[0] = '0;
    made[1] = '0;
    if (w.end_of_text) begin
      if (num.open_num) begin
        made[n] = close_number();
        n++;
      end
    end else if (w.ch >= CH_0 && w.ch <= CH_9) begin
      d = 64'(w.ch - CH_0);
      if (!num.open_num) begin
        num = '0;
        num.open_num = 1'b1;
        num.value = d[MANT_W-1:0];
      end else begin
        if (num.value > (MANT_MAX - d) / 10) begin
          num.value = MANT_MAX[MANT_W-1:0];
          num.clipped = 1'b1;
        end else begin
          num.value = MANT_W'(64'(num.value) * 64'd10 + d);
        end
        // fraction count sticks at its max, digits still go in
        if (num.after_point) begin
          if (num.places == FRAC_MAX) begin
            num.clipped = 1'b1;
          end else begin
            num.places = num.places + 1'b1;
          end
        end
      end
    end else if (w.ch == CH_POINT) begin
      if (num.open_num) begin
        if (!num.after_point) begin
          num.after_point = 1'b1;
        end else begin
          made[n] = close_number();
          n++;
        end
      end
    end else begin
      if (num.open_num) begin
        made[n] = close_number();
        n++;
      end
      case (w.ch)
        CH_PLUS: begin
          made[n] = make_tok(KIND_ADD, 64'd0, 4'd0, 1'b0, 1'b0);
          n++;
        end
        CH_MINUS: begin
          made[n] = make_tok(KIND_SUB, 64'd0, 4'd0, 1'b0, 1'b0);
          n++;
        end
        CH_STAR: begin
          made[n] = make_tok(KIND_MUL, 64'd0, 4'd0, 1'b0, 1'b0);
          n++;
        end
        CH_SLASH: begin
          made[n] = make_tok(KIND_DIV, 64'd0, 4'd0, 1'b0, 1'b0);
          n++;
        end
        default: ;
      endcase
    end
    if (n > 0) made[n-1].last_of_run = 1'b1;
    return n;
  endfunction

  function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_token(tok_t got);
    tok_t want;
    if (got.token_kind < 6) kind_seen[got.token_kind]++;
    if (got.overflow === 1'b1) clipped_seen++;
    if (expected_tokens.size() == 0) begin
      $error("token word with nothing expected: kind %0d mantissa %0d",
             got.token_kind, got.mantissa);
      mismatches++;
      return;
    end
    want = expected_tokens.pop_front();
    cmp_field("token_kind", 64'(want.token_kind), 64'(got.token_kind));
    cmp_field("mantissa", 64'(want.mantissa), 64'(got.mantissa));
    cmp_field("fraction_digits", 64'(want.fraction_digits), 64'(got.fraction_digits));
    cmp_field("overflow", 64'(want.overflow), 64'(got.overflow));
    cmp_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
  endfunction

  always @(posedge clk) begin
    char_row_t  row;
    tok_t       made[2];
    num_state_t prev;
    int         n;
    int         i;
    bit         moved;
    if (!rst) begin
      moved = 1'b0;
      if (src_valid && !src_stall) begin
        moved = 1'b1;
        row = offered_rows.pop_front();
        prev = num;
        n = tokenize_word(src_word, made);
        chars_seen++;
        if (n > 0 || num != prev) chars_used++;
        if (row.typed) begin
          expected_tokens.push_back(row.tok);
        end else begin
          for (i = 0; i < n; i++) expected_tokens.push_back(made[i]);
        end
      end
      if (tok_valid && !tok_stall) begin
        moved = 1'b1;
        check_token(tok_word);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // token side: random stall bursts, quiet stretches, one long hold-off on request
  initial begin
    int   r;
    int   n;
    logic s;
    tok_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      r = $urandom_range(99);
      if (hold_req) begin
        hold_req = 1'b0;
        s = 1'b1;
        n = HOLD_CYCLES;
      end else if (r < 4) begin
        s = 1'b0;
        n = 80;
      end else if (r < 65) begin
        s = 1'b0;
        n = $urandom_range(1, 8);
      end else if (r < 95) begin
        s = 1'b1;
        n = $urandom_range(1, 3);
      end else begin
        s = 1'b1;
        n = $urandom_range(15, 50);
      end
      tok_stall <= s;
      repeat (n) @(negedge clk);
    end
  end

  function automatic int sender_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(src_t w, bit typed, tok_t t);
    char_row_t row;
    int        gap;
    row.word = w;
    row.typed = typed;
    row.tok = t;
    if (sent_chars % 64 == 0) no_gaps = ($urandom_range(3) == 0);
    sent_chars++;
    gap = sender_gap();
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    offered_rows.push_back(row);
    src_word <= w;
    src_valid <= 1'b1;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_char(logic [7:0] c, logic eot);
    src_t w;
    w.ch = c;
    w.end_of_text = eot;
    send_word(w, 1'b0, '0);
  endtask

  task automatic send_digits(int n);
    int i;
    logic [7:0] c;
    for (i = 0; i < n; i++) begin
      c = CH_0 + 8'($urandom_range(9));
      send_char(c, 1'b0);
    end
  endtask

  task automatic wait_drained();
    src_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly a number plus terminator, some noise words
  task automatic send_expression();
    int r;
    int n;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 15) begin
      b = 8'($urandom_range(255));
      send_char(b, $urandom_range(7) == 0);
      return;
    end
    if ($urandom_range(9) == 0) send_char(CH_SPACE, 1'b0);
    r = $urandom_range(99);
    n = r < 70 ? $urandom_range(1, 4) : r < 90 ? $urandom_range(5, 9) : $urandom_range(10, 13);
    send_digits(n);
    if ($urandom_range(9) < 4) begin
      send_char(CH_POINT, 1'b0);
      r = $urandom_range(99);
      n = r < 70 ? $urandom_range(0, 5) : r < 90 ? $urandom_range(6, 12)
                                                  : $urandom_range(14, 19);
      send_digits(n);
    end
    r = $urandom_range(99);
    b = 8'($urandom_range(255));
    if (r < 55) begin
      case ($urandom_range(3))
        0: b = CH_PLUS;
        1: b = CH_MINUS;
        2: b = CH_STAR;
        default: b = CH_SLASH;
      endcase
      send_char(b, 1'b0);
    end else if (r < 70) begin
      send_char(CH_SPACE, 1'b0);
    end else if (r < 80) begin
      send_char(b, 1'b1);
    end else if (r < 88) begin
      send_char(CH_POINT, 1'b0);
    end else begin
      send_char(b, 1'b0);
    end
  endtask

  task automatic add_row(logic [7:0] c, logic eot, bit typed, tok_t t);
    char_row_t row;
    row.word.ch = c;
    row.word.end_of_text = eot;
    row.typed = typed;
    row.tok = t;
    directed_rows.push_back(row);
  endtask

  task automatic add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, '0);
  endtask

  task automatic run_stimulus();
    int base;
    bit held;
    bit paused;
    held = 1'b0;
    paused = 1'b0;
    add_text(".");
    add_row(8'hff, 1'b1, 1'b0, '0);
    add_row(CH_SLASH, 1'b0, 1'b1, make_tok(KIND_DIV, 64'd0, 4'd0, 1'b0, 1'b1));
    // mantissa and fraction count both clip, second point closes it
    add_text("9.9999999999999999");
    add_row(CH_POINT, 1'b0, 1'b1, make_tok(KIND_DEC, MANT_MAX, FRAC_MAX, 1'b1, 1'b1));
    // end marker carries a plus that must be ignored
    add_text("0.");
    add_row(CH_PLUS, 1'b1, 1'b1, make_tok(KIND_DEC, 64'd0, 4'd0, 1'b0, 1'b1));
    add_text("3");
    add_row(8'h00, 1'b0, 1'b1, make_tok(KIND_INT, 64'd3, 4'd0, 1'b0, 1'b1));
    add_text("5*");
    add_row(CH_PLUS, 1'b0, 1'b1, make_tok(KIND_ADD, 64'd0, 4'd0, 1'b0, 1'b1));
    add_row(CH_MINUS, 1'b0, 1'b1, make_tok(KIND_SUB, 64'd0, 4'd0, 1'b0, 1'b1));
    foreach (directed_rows[k])
      send_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].tok);
    wait_drained();

    base = chars_used;
    while (chars_used - base < RANDOM_WORDS) begin
      if (!held && chars_used - base > 500) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && chars_used - base > 1000) begin
        paused = 1'b1;
        wait_drained();
      end
      send_expression();
    end

    src_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    bit timed_out;
    rst = 1'b1;
    src_valid = 1'b0;
    src_word = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    fork
      run_stimulus();
      wait (idle_cycles >= IDLE_LIMIT);
    join_any
    disable fork;
    timed_out = idle_cycles >= IDLE_LIMIT;
    if (timed_out) $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    if (!timed_out && expected_tokens.size() != 0) begin
      $error("%0d expected tokens never arrived", expected_tokens.size());
      mismatches++;
    end
    $display("Characters accepted: %0d (%0d changed state or made tokens)",
             chars_seen, chars_used);
    $display("Tokens: %0d integer, %0d decimal, %0d operator, %0d clipped",
             kind_seen[0], kind_seen[1],
             kind_seen[2] + kind_seen[3] + kind_seen[4] + kind_seen[5], clipped_seen);
    if (!timed_out && mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
